@@ design/rfa_pkg.sv @@
// Shared widths, constants and word types for the radial falloff alpha generator.
package rfa_pkg;

  localparam int COORD_W      = 10;
  localparam int CFG_W        = 11;
  localparam int IDX_W        = 20;
  localparam int ALPHA_W      = 8;
  localparam int MAX_SIZE_DEF = 1024;
  localparam int SIZE_W_DEF   = 11;
  localparam int RESET_SIZE   = 256;

  localparam int DX_W = COORD_W + 2;
  localparam int S_W  = 2 * DX_W - 1;

  localparam int QW         = 32;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = QW / DIV_STEPS;

  localparam int RT_W      = QW / 2;
  localparam int SQ_RW     = RT_W + 3;
  localparam int SQ_STEPS  = 2;
  localparam int SQ_STAGES = RT_W / SQ_STEPS;

  localparam int F_W         = RT_W + 1;
  localparam int SQUARINGS   = 3;
  localparam int PWR_STAGES  = SQUARINGS + 2;
  localparam int ALPHA_SCALE = 255;
  localparam int SCALE_W     = F_W + ALPHA_W;

  localparam logic [F_W-1:0] ONE_Q16 = F_W'(1) << RT_W;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             sat;
  } tag_t;

endpackage

@@ design/radial_falloff_alpha_generator.sv @@
// Radial falloff alpha generator top level: size register and the pixel pipeline.
// Pipeline: 32 register stages lie between the edge that accepts a word and out_valid.
// Throughput: one word per cycle; stages hold their word on stall and bubbles close up.
// Depth is set by the 16-stage divider and 8-stage square root, two result bits per stage.
// Reset clears every stage valid bit and loads image size 256; the size square is registered in the next cycle.
module radial_falloff_alpha_generator #(
  parameter int MAX_SIZE = rfa_pkg::MAX_SIZE_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [rfa_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [rfa_pkg::COORD_W-1:0]  in_pixel_x,
  input  logic [rfa_pkg::COORD_W-1:0]  in_pixel_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rfa_pkg::IDX_W-1:0]    out_pixel_index,
  output logic [rfa_pkg::ALPHA_W-1:0]  out_alpha
);

  localparam int SZ_FIT = $clog2(MAX_SIZE + 1);
  localparam int SZ_W = (SZ_FIT < rfa_pkg::CFG_W) ? SZ_FIT : rfa_pkg::CFG_W;
  localparam int RW = 2 * SZ_W + 1;

  logic [SZ_W-1:0]   size_r, size_nxt;
  logic [2*SZ_W-1:0] size_sq_r;

  logic                    fr_ready, fr_valid, dv_ready, dv_valid;
  logic                    sq_ready, sq_valid, pw_ready;
  rfa_pkg::tag_t           fr_tag, dv_tag, sq_tag;
  logic [RW-1:0]           fr_rem;
  logic [rfa_pkg::QW-1:0]  dv_quo;
  logic [rfa_pkg::RT_W-1:0] sq_root;

  assign size_nxt = (32'(cfg_wr_data) > 32'(MAX_SIZE)) ? SZ_W'(MAX_SIZE) : SZ_W'(cfg_wr_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SZ_W'(rfa_pkg::RESET_SIZE);
    end else if (cfg_wr_en) begin
      size_r <= size_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_sq_r <= (2*SZ_W)'(size_r) * (2*SZ_W)'(size_r);
  end

  assign in_stall = !fr_ready;

  rfa_front #(.SIZE_W(SZ_W)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .size      (size_r),
    .size_sq   (size_sq_r),
    .in_valid  (in_valid),
    .in_ready  (fr_ready),
    .in_x      (in_pixel_x),
    .in_y      (in_pixel_y),
    .out_valid (fr_valid),
    .out_ready (dv_ready),
    .out_tag   (fr_tag),
    .out_rem   (fr_rem)
  );

  rfa_div #(.SIZE_W(SZ_W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .divisor   (size_sq_r),
    .in_valid  (fr_valid),
    .in_ready  (dv_ready),
    .in_tag    (fr_tag),
    .in_rem    (fr_rem),
    .out_valid (dv_valid),
    .out_ready (sq_ready),
    .out_tag   (dv_tag),
    .out_quo   (dv_quo)
  );

  rfa_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv_valid),
    .in_ready  (sq_ready),
    .in_tag    (dv_tag),
    .in_rad    (dv_quo),
    .out_valid (sq_valid),
    .out_ready (pw_ready),
    .out_tag   (sq_tag),
    .out_root  (sq_root)
  );

  rfa_power u_power (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid),
    .in_ready  (pw_ready),
    .in_tag    (sq_tag),
    .in_root   (sq_root),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .out_idx   (out_pixel_index),
    .out_alpha (out_alpha)
  );

endmodule

@@ design/rfa_front.sv @@
// Front stages: centered offsets, linear index, squared distance, range check.
module rfa_front #(
  parameter int SIZE_W = rfa_pkg::SIZE_W_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [SIZE_W-1:0]            size,
  input  logic [2*SIZE_W-1:0]          size_sq,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rfa_pkg::COORD_W-1:0]  in_x,
  input  logic [rfa_pkg::COORD_W-1:0]  in_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output rfa_pkg::tag_t                out_tag,
  output logic [2*SIZE_W:0]            out_rem
);

  localparam int RW = 2 * SIZE_W + 1;
  localparam int DX_W = rfa_pkg::DX_W;
  localparam int S_W = rfa_pkg::S_W;
  localparam int IDX_W = rfa_pkg::IDX_W;

  logic [2:0] v_r;
  logic [3:0] rdy;

  logic signed [DX_W-1:0] dx_r, dy_r, dx_nxt, dy_nxt;
  logic [IDX_W-1:0] idx1_r, idx2_r, idx_nxt;
  logic signed [2*DX_W-1:0] px, py, ps;
  logic [S_W-1:0] s_r, s_nxt;
  rfa_pkg::tag_t tag_r, tag_nxt;
  logic [RW-1:0] rem_r;

  assign rdy[3] = out_ready;
  assign rdy[2] = !v_r[2] || rdy[3];
  assign rdy[1] = !v_r[1] || rdy[2];
  assign rdy[0] = !v_r[0] || rdy[1];
  assign in_ready = rdy[0];

  assign dx_nxt = $signed({1'b0, in_x, 1'b0}) - $signed(DX_W'(size));
  assign dy_nxt = $signed({1'b0, in_y, 1'b0}) - $signed(DX_W'(size));
  assign idx_nxt = IDX_W'(32'(in_x) + 32'(in_y) * 32'(size));

  assign px = dx_r * dx_r;
  assign py = dy_r * dy_r;
  assign ps = px + py;
  assign s_nxt = ps[S_W-1:0];

  assign tag_nxt.idx = idx2_r;
  assign tag_nxt.sat = s_r >= S_W'({size_sq, 1'b0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
      if (rdy[2]) v_r[2] <= v_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      dx_r   <= dx_nxt;
      dy_r   <= dy_nxt;
      idx1_r <= idx_nxt;
    end
    if (rdy[1]) begin
      s_r    <= s_nxt;
      idx2_r <= idx1_r;
    end
    if (rdy[2]) begin
      tag_r <= tag_nxt;
      rem_r <= s_r[RW-1:0];
    end
  end

  assign out_valid = v_r[2];
  assign out_tag   = tag_r;
  assign out_rem   = rem_r;

endmodule

@@ design/rfa_div.sv @@
// Pipelined restoring divider: squared distance over squared size, Q1.31 quotient.
module rfa_div #(
  parameter int SIZE_W = rfa_pkg::SIZE_W_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [2*SIZE_W-1:0]      divisor,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  rfa_pkg::tag_t            in_tag,
  input  logic [2*SIZE_W:0]        in_rem,
  output logic                     out_valid,
  input  logic                     out_ready,
  output rfa_pkg::tag_t            out_tag,
  output logic [rfa_pkg::QW-1:0]   out_quo
);

  localparam int RW = 2 * SIZE_W + 1;
  localparam int QW = rfa_pkg::QW;
  localparam int NS = rfa_pkg::DIV_STAGES;
  localparam int STEPS = rfa_pkg::DIV_STEPS;

  logic          v_r     [NS];
  logic [NS:0]   rdy;
  logic [RW-1:0] rem_r   [NS];
  logic [QW-1:0] quo_r   [NS];
  rfa_pkg::tag_t tag_r   [NS];
  logic          src_v   [NS];
  logic [RW-1:0] src_rem [NS];
  logic [QW-1:0] src_quo [NS];
  rfa_pkg::tag_t src_tag [NS];
  logic [RW-1:0] rem_nxt [NS];
  logic [QW-1:0] quo_nxt [NS];
  logic [RW-1:0] dv;

  assign dv = RW'(divisor);
  assign rdy[NS] = out_ready;
  assign in_ready = rdy[0];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    if (s == 0) begin : g_head
      assign src_v[s]   = in_valid;
      assign src_rem[s] = in_rem;
      assign src_quo[s] = '0;
      assign src_tag[s] = in_tag;
    end else begin : g_link
      assign src_v[s]   = v_r[s-1];
      assign src_rem[s] = rem_r[s-1];
      assign src_quo[s] = quo_r[s-1];
      assign src_tag[s] = tag_r[s-1];
    end

    assign rdy[s] = !v_r[s] || rdy[s+1];

    always_comb begin
      logic [RW-1:0] r;
      logic [QW-1:0] q;
      r = src_rem[s];
      q = src_quo[s];
      for (int k = 0; k < STEPS; k++) begin
        if (r >= dv) begin
          r = r - dv;
          q = {q[QW-2:0], 1'b1};
        end else begin
          q = {q[QW-2:0], 1'b0};
        end
        r = {r[RW-2:0], 1'b0};
      end
      rem_nxt[s] = r;
      quo_nxt[s] = q;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_r[s] <= src_v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        rem_r[s] <= rem_nxt[s];
        quo_r[s] <= quo_nxt[s];
        tag_r[s] <= src_tag[s];
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_tag   = tag_r[NS-1];
  assign out_quo   = quo_r[NS-1];

endmodule

@@ design/rfa_sqrt.sv @@
// Pipelined digit-by-digit square root of the 32-bit ratio read as Q0.32, Q0.16 result.
module rfa_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  rfa_pkg::tag_t              in_tag,
  input  logic [rfa_pkg::QW-1:0]     in_rad,
  output logic                       out_valid,
  input  logic                       out_ready,
  output rfa_pkg::tag_t              out_tag,
  output logic [rfa_pkg::RT_W-1:0]   out_root
);

  localparam int QW = rfa_pkg::QW;
  localparam int RT_W = rfa_pkg::RT_W;
  localparam int RW = rfa_pkg::SQ_RW;
  localparam int NS = rfa_pkg::SQ_STAGES;
  localparam int STEPS = rfa_pkg::SQ_STEPS;

  logic            v_r      [NS];
  logic [NS:0]     rdy;
  logic [RW-1:0]   rem_r    [NS];
  logic [QW-1:0]   rad_r    [NS];
  logic [RT_W-1:0] root_r   [NS];
  rfa_pkg::tag_t   tag_r    [NS];
  logic            src_v    [NS];
  logic [RW-1:0]   src_rem  [NS];
  logic [QW-1:0]   src_rad  [NS];
  logic [RT_W-1:0] src_root [NS];
  rfa_pkg::tag_t   src_tag  [NS];
  logic [RW-1:0]   rem_nxt  [NS];
  logic [QW-1:0]   rad_nxt  [NS];
  logic [RT_W-1:0] root_nxt [NS];

  assign rdy[NS] = out_ready;
  assign in_ready = rdy[0];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    if (s == 0) begin : g_head
      assign src_v[s]    = in_valid;
      assign src_rem[s]  = '0;
      assign src_rad[s]  = in_rad;
      assign src_root[s] = '0;
      assign src_tag[s]  = in_tag;
    end else begin : g_link
      assign src_v[s]    = v_r[s-1];
      assign src_rem[s]  = rem_r[s-1];
      assign src_rad[s]  = rad_r[s-1];
      assign src_root[s] = root_r[s-1];
      assign src_tag[s]  = tag_r[s-1];
    end

    assign rdy[s] = !v_r[s] || rdy[s+1];

    always_comb begin
      logic [RW-1:0]   r;
      logic [QW-1:0]   a;
      logic [RT_W-1:0] t;
      logic [RW-1:0]   trial;
      r = src_rem[s];
      a = src_rad[s];
      t = src_root[s];
      for (int k = 0; k < STEPS; k++) begin
        r = {r[RW-3:0], a[QW-1:QW-2]};
        a = {a[QW-3:0], 2'b00};
        trial = RW'({t, 2'b01});
        if (r >= trial) begin
          r = r - trial;
          t = {t[RT_W-2:0], 1'b1};
        end else begin
          t = {t[RT_W-2:0], 1'b0};
        end
      end
      rem_nxt[s]  = r;
      rad_nxt[s]  = a;
      root_nxt[s] = t;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_r[s] <= src_v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        rem_r[s]  <= rem_nxt[s];
        rad_r[s]  <= rad_nxt[s];
        root_r[s] <= root_nxt[s];
        tag_r[s]  <= src_tag[s];
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_tag   = tag_r[NS-1];
  assign out_root  = root_r[NS-1];

endmodule

@@ design/rfa_power.sv @@
// Falloff, three truncating squarings and the 255 scale, one stage each.
module rfa_power (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rfa_pkg::tag_t                 in_tag,
  input  logic [rfa_pkg::RT_W-1:0]      in_root,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rfa_pkg::IDX_W-1:0]     out_idx,
  output logic [rfa_pkg::ALPHA_W-1:0]   out_alpha
);

  localparam int F_W = rfa_pkg::F_W;
  localparam int RT_W = rfa_pkg::RT_W;
  localparam int NS = rfa_pkg::PWR_STAGES;
  localparam int AW = rfa_pkg::ALPHA_W;
  localparam int SC_W = rfa_pkg::SCALE_W;

  logic             v_r     [NS];
  logic [NS:0]      rdy;
  logic [F_W-1:0]   f_r     [NS-1];
  rfa_pkg::tag_t    tag_r   [NS];
  logic [AW-1:0]    alpha_r;
  logic [F_W-1:0]   f_nxt   [NS-1];
  logic [SC_W-1:0]  scaled;

  assign rdy[NS] = out_ready;
  assign in_ready = rdy[0];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    assign rdy[s] = !v_r[s] || rdy[s+1];

    if (s == 0) begin : g_head
      assign f_nxt[s] = in_tag.sat ? '0 : rfa_pkg::ONE_Q16 - F_W'(in_root);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[s] <= 1'b0;
        end else if (rdy[s]) begin
          v_r[s] <= in_valid;
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[s]) begin
          f_r[s]   <= f_nxt[s];
          tag_r[s] <= in_tag;
        end
      end
    end else begin : g_link
      if (s < NS - 1) begin : g_square
        logic [2*F_W-1:0] prod;
        assign prod = (2*F_W)'(f_r[s-1]) * (2*F_W)'(f_r[s-1]);
        assign f_nxt[s] = prod[RT_W+F_W-1:RT_W];

        always_ff @(posedge clk) begin
          if (rdy[s]) begin
            f_r[s] <= f_nxt[s];
          end
        end
      end else begin : g_scale
        assign scaled = SC_W'(f_r[s-1]) * SC_W'(rfa_pkg::ALPHA_SCALE);

        always_ff @(posedge clk) begin
          if (rdy[s]) begin
            alpha_r <= scaled[RT_W+AW-1:RT_W];
          end
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[s] <= 1'b0;
        end else if (rdy[s]) begin
          v_r[s] <= v_r[s-1];
        end
      end

      always_ff @(posedge clk) begin
        if (rdy[s]) begin
          tag_r[s] <= tag_r[s-1];
        end
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_idx   = tag_r[NS-1].idx;
  assign out_alpha = alpha_r;

endmodule

@@ tb/sv/radial_falloff_alpha_generator_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the radial falloff alpha generator: predictor, stimulus, checker.
module radial_falloff_alpha_generator_tb;
  import rfa_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]   index;
    logic [ALPHA_W-1:0] alpha;
  } pixel_word_t;

  class falloff_tracker;
    int unsigned image_size = RESET_SIZE;
    int unsigned failures = 0;
    pixel_word_t pending_pixels[$];

    function void set_size(logic [CFG_W-1:0] v);
      image_size = (v > MAX_SIZE_DEF) ? MAX_SIZE_DEF : v;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, t;
      r = 0;
      for (int b = 27; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    function logic [ALPHA_W-1:0] falloff_alpha(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      longint dx, dy;
      longint unsigned sq, ratio2, root, f, sz;
      if (image_size == 0) return '0;
      sz = 64'(image_size);
      dx = 2 * longint'(x) - longint'(sz);
      dy = 2 * longint'(y) - longint'(sz);
      sq = dx * dx + dy * dy;
      ratio2 = (sq << 31) / (sz * sz);
      root = int_sqrt(ratio2);
      if (root > 65536) root = 65536;
      f = 65536 - root;
      repeat (SQUARINGS) f = (f * f) >> 16;
      return ALPHA_W'((f * ALPHA_SCALE) >> 16);
    endfunction

    function void note_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      pixel_word_t w;
      longint unsigned idx;
      idx = longint'(x) + longint'(y) * longint'(image_size);
      w.index = IDX_W'(idx);
      w.alpha = falloff_alpha(x, y);
      pending_pixels.push_back(w);
    endfunction

    function void check_pixel(logic [IDX_W-1:0] index, logic [ALPHA_W-1:0] alpha);
      pixel_word_t w;
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual index %0d alpha %0d",
                 $time, index, alpha);
        failures++;
        return;
      end
      w = pending_pixels.pop_front();
      if (index !== w.index) begin
        $display("%0t: pixel_index mismatch, expected %0d, actual %0d", $time, w.index, index);
        failures++;
      end
      if (alpha !== w.alpha) begin
        $display("%0t: alpha mismatch, expected %0d, actual %0d", $time, w.alpha, alpha);
        failures++;
      end
    endfunction

    function int outstanding();
      return pending_pixels.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]    cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [COORD_W-1:0]  in_pixel_x = '0;
  logic [COORD_W-1:0]  in_pixel_y = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [IDX_W-1:0]    out_pixel_index;
  logic [ALPHA_W-1:0]  out_alpha;

  falloff_tracker tracker = new;
  int tx_idle_pct = 13;
  int rx_idle_pct = 50;
  bit long_hold_req = 1'b0;
  int hold_left = 0;

  radial_falloff_alpha_generator uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_index (out_pixel_index),
    .out_alpha       (out_alpha)
  );

  always #6 clk = ~clk;

  // receiver: random stall, plus one long hold-off so the pipe fills
  always @(negedge clk) begin
    if (long_hold_req) begin
      hold_left = 120;
      long_hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_pixel(out_pixel_index, out_alpha);
  end

  task send_word(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_pixel_x <= x;
    in_pixel_y <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_pixel(x, y);
    @(negedge clk);
  endtask

  task write_size(logic [CFG_W-1:0] v);
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_size(v);
    repeat (2) @(negedge clk);
  endtask

  task random_pixels(int count);
    int unsigned sz;
    logic [COORD_W-1:0] x, y;
    sz = tracker.image_size;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0: begin
          x = COORD_W'($urandom_range(0, 1023));
          y = COORD_W'($urandom_range(0, 1023));
        end
        1: begin
          case ($urandom_range(0, 4))
            0: x = '0;
            1: x = COORD_W'((sz > 0) ? sz - 1 : 0);
            2: x = COORD_W'(sz);
            3: x = '1;
            default: x = COORD_W'(sz / 2);
          endcase
          y = (sz > 0) ? COORD_W'($urandom_range(0, sz - 1)) : COORD_W'($urandom_range(0, 1023));
        end
        default: begin
          if (sz == 0) begin
            x = COORD_W'($urandom_range(0, 1023));
            y = COORD_W'($urandom_range(0, 1023));
          end else begin
            x = COORD_W'($urandom_range(0, sz - 1));
            y = COORD_W'($urandom_range(0, sz - 1));
          end
        end
      endcase
      send_word(x, y);
    end
  endtask

  initial begin
    int seg_size[10];
    seg_size = '{1024, 256, 2047, 1, 0, 3, 1025, 513, 0, 0};
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // directed at reset size 256: centre, corners, edges, outside; then after size writes of 1, 0 and 2047
    send_word(10'd128, 10'd128);
    send_word(10'd0, 10'd0);
    send_word(10'd255, 10'd255);
    send_word(10'd0, 10'd255);
    send_word(10'd255, 10'd0);
    send_word(10'd1023, 10'd1023);
    send_word(10'd1023, 10'd0);
    send_word(10'd0, 10'd1023);
    send_word(10'd256, 10'd256);
    send_word(10'd127, 10'd127);
    send_word(10'd129, 10'd128);
    send_word(10'd64, 10'd200);
    send_word(10'd1023, 10'd512);
    send_word(10'd512, 10'd1023);
    send_word(10'd256, 10'd0);
    write_size(11'd1);
    send_word(10'd0, 10'd0);
    send_word(10'd1, 10'd1);
    send_word(10'd1023, 10'd1023);
    write_size(11'd0);
    send_word(10'd5, 10'd7);
    send_word(10'd1023, 10'd1023);
    write_size(11'd2047);
    send_word(10'd1023, 10'd1023);
    send_word(10'd512, 10'd512);
    send_word(10'd0, 10'd0);
    send_word(10'd511, 10'd512);

    for (int seg = 0; seg < 10; seg++) begin
      if (seg == 8) seg_size[seg] = $urandom_range(2, 1024);
      if (seg == 9) seg_size[seg] = $urandom_range(0, 2047);
      write_size(CFG_W'(seg_size[seg]));
      if (seg == 4) begin
        tx_idle_pct = 50;
        rx_idle_pct = 13;
      end
      if (seg == 7) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        long_hold_req = 1'b1;
      end
      random_pixels(65);
    end
    in_valid <= 1'b0;

    while (tracker.outstanding() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (tracker.failures == 0 && tracker.outstanding() == 0) begin
      $display("radial_falloff_alpha_generator regression: pass");
    end else begin
      $display("radial_falloff_alpha_generator regression: fail");
    end
    $finish;
  end

  initial begin
    #2_400_000;
    $display("radial_falloff_alpha_generator regression: fail");
    $finish;
  end

endmodule

@@ sim.f @@
design/rfa_pkg.sv
design/rfa_front.sv
design/rfa_div.sv
design/rfa_sqrt.sv
design/rfa_power.sv
design/radial_falloff_alpha_generator.sv
tb/sv/radial_falloff_alpha_generator_tb.sv
